[design/fltw_pkg.sv]
// Shared types and constants of the four-level page table walker.
package fltw_pkg;

   localparam int ADDR_W  = 52;
   localparam int VADDR_W = 48;
   localparam int ENTRY_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 112;

   localparam logic FUNC_TRANSLATE = 1'b0;
   localparam logic FUNC_ENTRY     = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_BUSY    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_TABLE_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGING_ENABLED  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIVE_LEVEL_MODE = 2'd2;

   localparam logic [1:0] LEVEL_PML4 = 2'd0;
   localparam logic [1:0] LEVEL_PDPT = 2'd1;
   localparam logic [1:0] LEVEL_PD   = 2'd2;
   localparam logic [1:0] LEVEL_PT   = 2'd3;

   localparam logic [ADDR_W-1:0] OFF_1G = 52'h3fffffff;
   localparam logic [ADDR_W-1:0] OFF_2M = 52'h1fffff;
   localparam logic [ADDR_W-1:0] OFF_4K = 52'hfff;

   localparam int PS_BIT = 7;

   typedef struct packed {
      logic [ADDR_W-1:0] root_table_base;
      logic              paging_enabled;
      logic              five_level_mode;
   } cfg_type;

   typedef struct packed {
      logic               busy;
      logic [1:0]         level;
      logic [VADDR_W-1:0] vaddr;
   } walk_state_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] read_addr;
      logic [ADDR_W-1:0] phys_addr;
      logic [1:0]        status;
   } result_type;

   function automatic logic [8:0] level_index(input logic [VADDR_W-1:0] va,
                                              input logic [1:0] level);
      logic [8:0] idx;
      case (level)
         LEVEL_PML4: begin
            idx = va[47:39];
         end
         LEVEL_PDPT: begin
            idx = va[38:30];
         end
         LEVEL_PD: begin
            idx = va[29:21];
         end
         default: begin
            idx = va[20:12];
         end
      endcase
      return idx;
   endfunction

endpackage

[design/fltw_step.sv]
// Single-word walk step: decodes one accepted word into a result, if it causes one, and the next walk state.
module fltw_step
   import fltw_pkg::*;
#(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  cfg_type              cfg,
   input  walk_state_type       state,
   input  logic                 func,
   input  logic [VADDR_W-1:0]   virt_addr,
   input  logic [ENTRY_W-1:0]   entry_data,
   output logic                 has_result,
   output result_type           result,
   output walk_state_type       next_state
);

   localparam logic [ADDR_W-1:0] PHYS_MASK =
      ADDR_W'((64'd1 << PHYS_ADDR_BITS) - 64'd1);

   logic [ADDR_W-1:0] root_frame;
   logic [ADDR_W-1:0] entry_bits;
   logic [ADDR_W-1:0] frame_4k;
   logic [ADDR_W-1:0] frame_2m;
   logic [ADDR_W-1:0] frame_1g;
   logic [ADDR_W-1:0] va_ext;
   logic [1:0]        next_level;
   logic [ADDR_W-1:0] walk_read_addr;
   logic              page_size;

   assign root_frame = cfg.root_table_base & PHYS_MASK & ~OFF_4K;
   assign entry_bits = entry_data[ADDR_W-1:0] & PHYS_MASK;
   assign frame_4k   = entry_bits & ~OFF_4K;
   assign frame_2m   = entry_bits & ~OFF_2M;
   assign frame_1g   = entry_bits & ~OFF_1G;
   assign va_ext     = {{(ADDR_W-VADDR_W){1'b0}}, state.vaddr};
   assign page_size  = entry_data[PS_BIT];
   assign next_level = state.level + 2'd1;
   assign walk_read_addr = (frame_4k | {40'd0, level_index(state.vaddr, next_level), 3'b000})
                           & PHYS_MASK;

   always_comb begin
      has_result = 1'b0;
      result     = '0;
      next_state = state;
      if (func == FUNC_TRANSLATE) begin
         has_result = 1'b1;
         result.kind = KIND_DONE;
         if (state.busy) begin
            result.status = STATUS_BUSY;
         end else if (virt_addr == '0 || !cfg.paging_enabled || cfg.five_level_mode) begin
            result.status = STATUS_REFUSED;
         end else begin
            next_state.busy  = 1'b1;
            next_state.level = LEVEL_PML4;
            next_state.vaddr = virt_addr;
            result.kind      = KIND_READ;
            result.read_addr = (root_frame | {40'd0, level_index(virt_addr, LEVEL_PML4), 3'b000})
                               & PHYS_MASK;
         end
      end else if (state.busy) begin
         has_result = 1'b1;
         if ((state.level == LEVEL_PT) ||
             (state.level == LEVEL_PDPT && page_size) ||
             (state.level == LEVEL_PD && page_size)) begin
            next_state.busy  = 1'b0;
            next_state.level = LEVEL_PML4;
            result.kind      = KIND_DONE;
            case (state.level)
               LEVEL_PDPT: begin
                  result.phys_addr = (frame_1g | (va_ext & OFF_1G)) & PHYS_MASK;
               end
               LEVEL_PD: begin
                  result.phys_addr = (frame_2m | (va_ext & OFF_2M)) & PHYS_MASK;
               end
               default: begin
                  result.phys_addr = (frame_4k | (va_ext & OFF_4K)) & PHYS_MASK;
               end
            endcase
         end else begin
            next_state.level = next_level;
            result.kind      = KIND_READ;
            result.read_addr = walk_read_addr;
         end
      end
   end

endmodule

[design/four_level_page_table_walker.sv]
// Top level of the four-level page table walker with its output skid stage.
//
// Words enter on the req_ channel: req_tuser is 0 for a translate request
// (virtual address in req_tdata) and 1 for a table entry read back from memory.
// Results leave on the rsp_ channel: rsp_tuser is 0 for a memory read of the
// entry address in read_addr and 1 for a finished translation with a status.
// A translate request causes one result, each entry word of a walk in progress
// causes one result, and an entry word while idle causes none.
// A result is registered into the output stage when its word is accepted.
// One word is accepted every cycle while req_tready is high; throughput is set by the two-entry output
// stage, which lets a new word in while a result waits for rsp_tready.
// When the receiver stalls long enough for both output entries to fill,
// req_tready drops until one entry drains.
// Configuration is written through csr_wr_en, csr_index and csr_wdata; the user
// must do so only while the block is idle; the block itself does not enforce this.
// A synchronous reset clears the walk state, the output stage and all
// configuration registers.
module four_level_page_table_walker
   import fltw_pkg::*;
#(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // virt_addr[47:0], entry_data[111:48]
   input  logic                   req_tuser,  // func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // read_addr[51:0], phys_addr[103:52],
                                              // status[105:104], zeros above
   output logic                   rsp_tuser,  // kind
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]      csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   walk_state_type state_ff, state_in;
   walk_state_type step_state;
   result_type     step_result;
   result_type     out_ff, out_in;
   result_type     skid_ff, skid_in;
   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   logic           step_has_result;
   logic           accept;
   logic           push;
   logic           pop;

   fltw_step #(
      .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
   ) u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .func       (req_tuser),
      .virt_addr  (req_tdata[VADDR_W-1:0]),
      .entry_data (req_tdata[VADDR_W+ENTRY_W-1:VADDR_W]),
      .has_result (step_has_result),
      .result     (step_result),
      .next_state (step_state)
   );

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && step_has_result;
   assign pop        = out_valid_ff && rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {{(RSP_DATA_W-2*ADDR_W-2){1'b0}}, out_ff.status,
                        out_ff.phys_addr, out_ff.read_addr};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ROOT_TABLE_BASE: begin
               cfg_in.root_table_base = csr_wdata;
            end
            CSR_PAGING_ENABLED: begin
               cfg_in.paging_enabled = csr_wdata[0];
            end
            CSR_FIVE_LEVEL_MODE: begin
               cfg_in.five_level_mode = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   assign state_in = accept ? step_state : state_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = step_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = step_result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         cfg_ff        <= '0;
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register is empty");

   read_keeps_walk: assert property (@(posedge clock) disable iff (reset)
      (push && step_result.kind == KIND_READ) |=> state_ff.busy)
      else $error("read request issued without an active walk");

   busy_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == FUNC_TRANSLATE && state_ff.busy) |=> $stable(state_ff))
      else $error("busy rejection disturbed the walk in progress");

   idle_entry_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == FUNC_ENTRY && !state_ff.busy) |-> !push)
      else $error("entry word while idle produced a result");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the four-level page table walker: directed table, then random walks.
module testbench;
   import fltw_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 1800;
   localparam int PHASE_WORDS  = 150;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 64;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic                       func;
      logic [VADDR_W-1:0]         va;
      logic [ENTRY_W-1:0]         value;
      logic [CSR_INDEX_W-1:0]     reg_index;
      bit                         pinned;
      result_type                 want;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ADDR_W-1:0]      csr_wdata;

   logic [ADDR_W-1:0]  cfg_root;
   logic               cfg_paging;
   logic               cfg_five;
   logic               walk_active;
   logic [1:0]         walk_depth;
   logic [VADDR_W-1:0] walk_vaddr;

   result_type   pending_results[$];
   stim_row_type directed_rows[$];
   bit           pin_valid;
   result_type   pin_result;

   int  error_count;
   int  cycle_count;
   int  n_predicted;
   int  results_seen;
   int  n_walks;
   int  n_refused;
   int  n_phases;
   int  hold_left;
   bit  hold_done;
   wire calm_stretch = (results_seen >= 700) && (results_seen < 1000);

   four_level_page_table_walker #(
      .PHYS_ADDR_BITS(52)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic logic [ADDR_W-1:0] table_read_addr(input logic [ADDR_W-1:0] base,
                                                         input logic [1:0] level,
                                                         input logic [VADDR_W-1:0] va);
      logic [VADDR_W-1:0] shifted;
      shifted = va >> (39 - 9 * int'(level));
      return {base[ADDR_W-1:12], 12'h000} + {40'd0, shifted[8:0], 3'b000};
   endfunction

   task automatic predict_walk_step(input logic func, input logic [VADDR_W-1:0] va,
                                    input logic [ENTRY_W-1:0] entry,
                                    output bit produced, output result_type res);
      produced = 1'b1;
      res = '0;
      if (func == FUNC_TRANSLATE) begin
         res.kind = KIND_DONE;
         if (walk_active) begin
            res.status = STATUS_BUSY;
         end else if (va == '0 || !cfg_paging || cfg_five) begin
            res.status = STATUS_REFUSED;
         end else begin
            walk_active = 1'b1;
            walk_vaddr = va;
            walk_depth = LEVEL_PML4;
            res.kind = KIND_READ;
            res.read_addr = table_read_addr(cfg_root, LEVEL_PML4, va);
         end
      end else if (!walk_active) begin
         produced = 1'b0;
      end else begin
         res.kind = KIND_DONE;
         res.status = STATUS_OK;
         case (walk_depth)
            LEVEL_PML4: begin
               res.kind = KIND_READ;
               walk_depth = LEVEL_PDPT;
            end
            LEVEL_PDPT: begin
               if (entry[PS_BIT]) begin
                  res.phys_addr = {entry[ADDR_W-1:30], walk_vaddr[29:0]};
               end else begin
                  res.kind = KIND_READ;
                  walk_depth = LEVEL_PD;
               end
            end
            LEVEL_PD: begin
               if (entry[PS_BIT]) begin
                  res.phys_addr = {entry[ADDR_W-1:21], walk_vaddr[20:0]};
               end else begin
                  res.kind = KIND_READ;
                  walk_depth = LEVEL_PT;
               end
            end
            default: begin
               res.phys_addr = {entry[ADDR_W-1:12], walk_vaddr[11:0]};
            end
         endcase
         if (res.kind == KIND_READ) begin
            res.read_addr = table_read_addr(entry[ADDR_W-1:0], walk_depth, walk_vaddr);
         end else begin
            walk_active = 1'b0;
            walk_depth = LEVEL_PML4;
         end
      end
   endtask

   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: kind %0d data %h",
                                   rsp_tuser, rsp_tdata));
         return;
      end
      want = pending_results.pop_front();
      results_seen++;
      if (rsp_tuser !== want.kind)
         report_mismatch($sformatf("kind %0d, expected %0d", rsp_tuser, want.kind));
      if (rsp_tdata[51:0] !== want.read_addr)
         report_mismatch($sformatf("read_addr %h, expected %h", rsp_tdata[51:0],
                                   want.read_addr));
      if (rsp_tdata[103:52] !== want.phys_addr)
         report_mismatch($sformatf("phys_addr %h, expected %h", rsp_tdata[103:52],
                                   want.phys_addr));
      if (rsp_tdata[105:104] !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_tdata[105:104],
                                   want.status));
      if (rsp_tdata[RSP_DATA_W-1:106] !== '0)
         report_mismatch($sformatf("padding bits %h, expected zero",
                                   rsp_tdata[RSP_DATA_W-1:106]));
      if (want.kind == KIND_DONE && want.status == STATUS_OK)
         n_walks++;
      else if (want.kind == KIND_DONE)
         n_refused++;
   endtask

   task automatic take_word();
      bit         produced;
      result_type res;
      predict_walk_step(req_tuser, req_tdata[VADDR_W-1:0], req_tdata[REQ_DATA_W-1:VADDR_W],
                        produced, res);
      if (produced) begin
         pending_results.push_back(pin_valid ? pin_result : res);
         n_predicted++;
      end else if (pin_valid) begin
         report_mismatch("directed row expects a result but the walk is idle");
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            take_word();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && results_seen >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm_stretch) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 13);
         end
      end
   end

   task automatic send_word(input logic func, input logic [VADDR_W-1:0] va,
                            input logic [ENTRY_W-1:0] entry,
                            input bit pinned, input result_type pin_res);
      if (!calm_stretch && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {entry, va};
      pin_valid = pinned;
      pin_result = pin_res;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [ADDR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_ROOT_TABLE_BASE: cfg_root = data;
         CSR_PAGING_ENABLED:  cfg_paging = data[0];
         CSR_FIVE_LEVEL_MODE: cfg_five = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [VADDR_W-1:0] random_vaddr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      if ($urandom_range(99) < 3)
         w = '0;
      return w[VADDR_W-1:0];
   endfunction

   function automatic logic [ENTRY_W-1:0] random_entry();
      logic [ENTRY_W-1:0] w;
      w = {$urandom, $urandom};
      w[PS_BIT] = ($urandom_range(99) < 30);
      return w;
   endfunction

   function automatic stim_row_type word_row(input logic func, input logic [VADDR_W-1:0] va,
                                             input logic [ENTRY_W-1:0] entry);
      stim_row_type r;
      r.kind = ROW_WORD;
      r.func = func;
      r.va = va;
      r.value = entry;
      r.reg_index = CSR_ROOT_TABLE_BASE;
      r.pinned = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic stim_row_type answered_row(input logic [VADDR_W-1:0] va,
                                                 input logic [1:0] status);
      stim_row_type r;
      r = word_row(FUNC_TRANSLATE, va, '0);
      r.pinned = 1'b1;
      r.want.kind = KIND_DONE;
      r.want.status = status;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_INDEX_W-1:0] index,
                                            input logic [ADDR_W-1:0] data);
      stim_row_type r;
      r = word_row(FUNC_TRANSLATE, '0, {12'h000, data});
      r.kind = ROW_CSR;
      r.reg_index = index;
      return r;
   endfunction

   task automatic run_sequence();
      int steps;
      if ($urandom_range(99) < 80) begin
         send_word(FUNC_TRANSLATE, random_vaddr(), random_entry(), 1'b0, '0);
         steps = 0;
         while (walk_active && steps < 6) begin
            if ($urandom_range(99) < 10)
               send_word(FUNC_TRANSLATE, random_vaddr(), random_entry(), 1'b0, '0);
            send_word(FUNC_ENTRY, random_vaddr(), random_entry(), 1'b0, '0);
            steps++;
         end
      end else begin
         send_word(1'($urandom_range(1)), random_vaddr(), random_entry(), 1'b0, '0);
      end
   endtask

   initial begin
      int          phase_end;
      int          target;
      logic [63:0] w;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = FUNC_TRANSLATE;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_ROOT_TABLE_BASE;
      csr_wdata = '0;
      pin_valid = 1'b0;
      pin_result = '0;
      cfg_root = '0;
      cfg_paging = 1'b0;
      cfg_five = 1'b0;
      walk_active = 1'b0;
      walk_depth = LEVEL_PML4;
      walk_vaddr = '0;
      error_count = 0;
      cycle_count = 0;
      n_predicted = 0;
      results_seen = 0;
      n_walks = 0;
      n_refused = 0;
      n_phases = 0;

      // Paging is off after reset, so a translation is refused.
      directed_rows.push_back(answered_row(48'h1234_5678_9abc, STATUS_REFUSED));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'hffff_ffff_ffff_ffff));
      directed_rows.push_back(csr_row(CSR_ROOT_TABLE_BASE, 52'hf_ffff_ffff_ffff));
      directed_rows.push_back(csr_row(CSR_PAGING_ENABLED, 52'h1));
      directed_rows.push_back(answered_row(48'h0, STATUS_REFUSED));
      directed_rows.push_back(word_row(FUNC_TRANSLATE, 48'hffff_ffff_ffff, '0));
      // While a walk runs, requests are busy, even one with a zero address.
      directed_rows.push_back(answered_row(48'h0000_0000_1000, STATUS_BUSY));
      directed_rows.push_back(answered_row(48'h0, STATUS_BUSY));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'hffff_ffff_ffff_ffff));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'hffff_ffff_ffff_ffff));
      directed_rows.push_back(word_row(FUNC_TRANSLATE, 48'h0000_0000_1000, '0));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'h000f_ffff_ffff_f000));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'hfff0_0000_0000_0f7f));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'h8000_0000_0000_0000));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'hffff_ffff_ffff_ffff));
      directed_rows.push_back(word_row(FUNC_TRANSLATE, 48'h7fff_ffff_ffff, '0));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'h0));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'h0));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'h000a_bcde_f01f_f080));
      directed_rows.push_back(csr_row(CSR_ROOT_TABLE_BASE, 52'h0));
      directed_rows.push_back(csr_row(CSR_FIVE_LEVEL_MODE, 52'h1));
      directed_rows.push_back(answered_row(48'hffff_ffff_ffff, STATUS_REFUSED));
      directed_rows.push_back(csr_row(CSR_FIVE_LEVEL_MODE, 52'h0));
      directed_rows.push_back(csr_row(CSR_PAGING_ENABLED, 52'hf_ffff_ffff_fffe));
      directed_rows.push_back(answered_row(48'h8000_0000_0000, STATUS_REFUSED));
      directed_rows.push_back(csr_row(CSR_PAGING_ENABLED, 52'h1));
      directed_rows.push_back(word_row(FUNC_TRANSLATE, 48'h8000_0000_0000, '0));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'h80));
      directed_rows.push_back(word_row(FUNC_ENTRY, '0, 64'h80));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (i == 0 || directed_rows[i-1].kind != ROW_CSR)
               settle_idle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].value[ADDR_W-1:0]);
            if (i + 1 == directed_rows.size() || directed_rows[i+1].kind != ROW_CSR)
               csr_wr_en <= 1'b0;
         end else begin
            send_word(directed_rows[i].func, directed_rows[i].va, directed_rows[i].value,
                      directed_rows[i].pinned, directed_rows[i].want);
         end
      end

      target = n_predicted + RANDOM_WORDS;
      while (n_predicted < target) begin
         settle_idle();
         n_phases++;
         case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            default: w = {$urandom, $urandom};
         endcase
         write_reg(CSR_ROOT_TABLE_BASE, w[ADDR_W-1:0]);
         w = {$urandom, $urandom};
         w[0] = ($urandom_range(9) != 0);
         write_reg(CSR_PAGING_ENABLED, w[ADDR_W-1:0]);
         w = {$urandom, $urandom};
         w[0] = ($urandom_range(9) == 0);
         write_reg(CSR_FIVE_LEVEL_MODE, w[ADDR_W-1:0]);
         csr_wr_en <= 1'b0;
         phase_end = n_predicted + PHASE_WORDS;
         while (n_predicted < phase_end && n_predicted < target)
            run_sequence();
         // A walk left open by noise is finished before the next settings.
         while (walk_active)
            send_word(FUNC_ENTRY, random_vaddr(), random_entry(), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      $display("Summary: %0d results checked, %0d finished translations, %0d refused or busy.",
               results_seen, n_walks, n_refused);
      $display("Summary: %0d random settings phases with receiver stalls and back-pressure.",
               n_phases);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches found.", error_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
design/fltw_pkg.sv
design/fltw_step.sv
design/four_level_page_table_walker.sv
verif/testbench.sv
